FILE: rtl/adq_pkg.sv
`timescale 1ns / 1ps

package adq_pkg;

   localparam int CFG_W  = 12;
   localparam int POS_W  = 13;
   localparam int QUAT_W = 16;

   localparam logic [CFG_W-1:0] FRAME_RESET = 12'd200;

   // register indexes of the configuration port
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_LEFT_PRESS  = 2'd0,
      FUNC_OTHER_PRESS = 2'd1,
      FUNC_MOVE        = 2'd2,
      FUNC_RELEASE     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REPORT_QUAT  = 2'd0,
      REPORT_START = 2'd1,
      REPORT_END   = 2'd2
   } report_type;

   typedef enum logic [1:0] {
      DIV_PLANE_X = 2'd0,
      DIV_PLANE_Y = 2'd1,
      DIV_NORM_X  = 2'd2,
      DIV_NORM_Y  = 2'd3
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MUL,
      S_ACC,
      S_NARROW,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_SPHERE,
      S_OUT
   } state_type;

   // product sequence: squares, dot, then the three cross terms
   typedef logic [3:0] mstep_type;
   localparam mstep_type STEP_UU      = 4'd0;
   localparam mstep_type STEP_VV      = 4'd1;
   localparam mstep_type STEP_DOT_XX  = 4'd2;
   localparam mstep_type STEP_DOT_YY  = 4'd3;
   localparam mstep_type STEP_DOT_END = 4'd4;
   localparam mstep_type STEP_CX_A    = 4'd5;
   localparam mstep_type STEP_CX_END  = 4'd6;
   localparam mstep_type STEP_CY_A    = 4'd7;
   localparam mstep_type STEP_CY_END  = 4'd8;
   localparam mstep_type STEP_CZ_A    = 4'd9;
   localparam mstep_type STEP_LAST    = 4'd10;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      logic        div_store;
      div_sel_type div_sel;
      logic        sqrt_start;
      logic        sqrt_store;
      logic        mul_go;
      logic        acc_go;
      logic        narrow_go;
      mstep_type   mstep;
      logic        commit_start;
      logic        out_load;
      report_type  out_kind;
   } cmd_type;

   typedef struct packed {
      logic     div_done;
      logic     sqrt_done;
      logic     need_norm;
      func_type func;
   } status_type;

   function automatic logic step_first(mstep_type s);
      logic r;
      case (s)
         STEP_UU, STEP_DOT_XX, STEP_CX_A, STEP_CY_A, STEP_CZ_A: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic step_sub(mstep_type s);
      logic r;
      case (s)
         STEP_CX_END, STEP_CY_END, STEP_LAST: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic step_last(mstep_type s);
      logic r;
      case (s)
         STEP_VV, STEP_DOT_END, STEP_CX_END, STEP_CY_END, STEP_LAST: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/adq_ctrl.sv
`timescale 1ns / 1ps

module adq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  adq_pkg::status_type status,
   output adq_pkg::cmd_type    cmd
);
   import adq_pkg::*;

   state_type   state_ff, state_in;
   div_sel_type div_sel_ff, div_sel_in;
   mstep_type   mstep_ff, mstep_in;
   report_type  kind_ff, kind_in;
   logic        dragging_ff, dragging_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_sel_ff   <= DIV_PLANE_X;
         mstep_ff     <= STEP_UU;
         kind_ff      <= REPORT_QUAT;
         dragging_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         mstep_ff     <= mstep_in;
         kind_ff      <= kind_in;
         dragging_ff  <= dragging_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      div_sel_in  = div_sel_ff;
      mstep_in    = mstep_ff;
      kind_in     = kind_ff;
      dragging_in = dragging_ff;
      req_stall   = 1'b1;
      cmd              = '0;
      cmd.div_sel      = div_sel_ff;
      cmd.mstep        = mstep_ff;
      cmd.out_kind     = kind_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               FUNC_LEFT_PRESS: begin
                  div_sel_in = DIV_PLANE_X;
                  state_in   = S_DIV_GO;
               end
               FUNC_MOVE: begin
                  div_sel_in = DIV_PLANE_X;
                  state_in   = dragging_ff ? S_DIV_GO : S_IDLE;
               end
               FUNC_RELEASE: begin
                  if (dragging_ff) begin
                     dragging_in = 1'b0;
                     kind_in     = REPORT_END;
                     state_in    = S_OUT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               case (div_sel_ff)
                  DIV_PLANE_X: begin
                     div_sel_in = DIV_PLANE_Y;
                     state_in   = S_DIV_GO;
                  end
                  DIV_PLANE_Y: begin
                     mstep_in = STEP_UU;
                     state_in = S_MUL;
                  end
                  DIV_NORM_X: begin
                     div_sel_in = DIV_NORM_Y;
                     state_in   = S_DIV_GO;
                  end
                  default: state_in = S_SPHERE;
               endcase
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_go = 1'b1;
            if (mstep_ff == STEP_VV) begin
               state_in = S_SQRT_GO;
            end else if (step_last(mstep_ff)) begin
               state_in = S_NARROW;
            end else begin
               mstep_in = mstep_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_NARROW: begin
            cmd.narrow_go = 1'b1;
            if (mstep_ff == STEP_LAST) begin
               kind_in  = REPORT_QUAT;
               state_in = S_OUT;
            end else begin
               mstep_in = mstep_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               cmd.sqrt_store = 1'b1;
               if (status.need_norm) begin
                  div_sel_in = DIV_NORM_X;
                  state_in   = S_DIV_GO;
               end else begin
                  state_in = S_SPHERE;
               end
            end
         end
         S_SPHERE: begin
            if (status.func == FUNC_LEFT_PRESS) begin
               cmd.commit_start = 1'b1;
               kind_in          = REPORT_START;
               state_in         = S_OUT;
            end else begin
               mstep_in = STEP_DOT_XX;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               if (kind_ff == REPORT_START) dragging_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a beat still waiting");

   a_div_store: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> status.div_done)
      else $error("quotient stored before divider finished");

   a_drag_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(dragging_ff) |-> $past(cmd.out_load && cmd.out_kind == REPORT_START))
      else $error("dragging set without a drag start report");

   a_quat_drag: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_kind == REPORT_QUAT) |-> dragging_ff)
      else $error("rotation reported while not dragging");

endmodule

FILE: rtl/adq_datapath.sv
`timescale 1ns / 1ps

module adq_datapath #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  adq_pkg::cmd_type                       cmd,
   output adq_pkg::status_type                    status,
   input  logic [1:0]                             req_func,
   input  logic signed [adq_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [adq_pkg::POS_W-1:0]       req_pos_y,
   input  logic                                   csr_valid,
   input  logic                                   csr_index,
   input  logic [adq_pkg::CFG_W-1:0]              csr_data,
   output logic [1:0]                             rsp_report_kind,
   output logic signed [adq_pkg::QUAT_W-1:0]      rsp_quat_w,
   output logic signed [adq_pkg::QUAT_W-1:0]      rsp_quat_x,
   output logic signed [adq_pkg::QUAT_W-1:0]      rsp_quat_y,
   output logic signed [adq_pkg::QUAT_W-1:0]      rsp_quat_z
);
   import adq_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int PW  = F + 5;
   localparam int SW  = F + 2;
   localparam int DW  = (F + 15 > 2 * F + 4) ? F + 15 : 2 * F + 4;
   localparam int VW  = (13 > F + 4) ? 13 : F + 4;
   localparam int CW  = $clog2(DW + 1);
   localparam int QW  = 2 * F + 8;
   localparam int RTW = F + 4;
   localparam int RRW = F + 7;
   localparam int SCW = $clog2(RTW + 1);
   localparam int AW  = 2 * PW;
   localparam int NMW = F + 17;

   localparam logic [PW-1:0]        LIM   = PW'(1) << (F + 3);
   localparam logic signed [AW-1:0] ONE2  = AW'(1) << (2 * F);
   localparam logic signed [AW-1:0] HALF  = AW'(1) << (F - 1);
   localparam logic signed [AW-1:0] QMAX  = (AW'(1) << (QUAT_W - 1)) - AW'(1);
   localparam logic signed [AW-1:0] QMIN  = -(AW'(1) << (QUAT_W - 1));

   // configuration
   logic [CFG_W-1:0] fw_ff, fw_in, fh_ff, fh_in;

   // captured item
   func_type                func_ff, func_in;
   logic signed [POS_W-1:0] px_ff, px_in, py_ff, py_in;

   // plane and sphere values
   logic signed [PW-1:0]  u_ff, u_in, v_ff, v_in;
   logic signed [SW-1:0]  nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [SW-1:0]  sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [RTW-1:0]        len_ff, len_in;

   // divider
   logic [DW-1:0] div_quo_ff, div_quo_in;
   logic [VW-1:0] div_den_ff, div_den_in, div_rem_ff, div_rem_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;
   logic          div_neg_ff, div_neg_in;

   // square root
   logic [QW-1:0]  sq_src_ff, sq_src_in;
   logic [RRW-1:0] sq_rem_ff, sq_rem_in;
   logic [RTW-1:0] root_ff, root_in;
   logic [SCW-1:0] sq_cnt_ff, sq_cnt_in;

   // multiply and accumulate
   logic signed [AW-1:0] prod_ff, prod_in, acc_ff, acc_in;

   // quaternion and output
   logic signed [QUAT_W-1:0] qw_ff, qw_in, qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [1:0]               kind_ff, kind_in;
   logic signed [QUAT_W-1:0] ow_ff, ow_in, ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;

   // operand setup
   logic signed [POS_W-1:0] p_sel;
   logic [CFG_W-1:0]        size_sel, w_eff;
   logic signed [NMW-1:0]   p_ext, w_ext, plane_num;
   logic [NMW-1:0]          plane_mag;
   logic signed [PW-1:0]    u_sel;
   logic [PW-1:0]           u_mag;
   logic [DW-1:0]           div_num;
   logic [VW-1:0]           div_d;
   logic                    div_sgn;
   logic [VW:0]             div_shift;
   logic                    div_fit;
   logic [PW-1:0]           div_mag;
   logic signed [PW-1:0]    div_res;
   logic [RRW-1:0]          sq_sh, sq_trial;
   logic                    sq_fit;
   logic                    need_norm;
   logic signed [PW-1:0]    mul_a, mul_b;
   logic signed [AW-1:0]    acc_base, rnd, shr;
   logic signed [QUAT_W-1:0] nar;

   assign need_norm = acc_ff > ONE2;

   always_comb begin
      p_sel     = (cmd.div_sel == DIV_PLANE_X) ? px_ff : py_ff;
      size_sel  = (cmd.div_sel == DIV_PLANE_X) ? fw_ff : fh_ff;
      w_eff     = (size_sel == '0) ? CFG_W'(1) : size_sel;
      p_ext     = NMW'(p_sel);
      w_ext     = NMW'($signed({1'b0, w_eff}));
      plane_num = (((p_ext <<< 1) - w_ext) <<< (F + 1)) + w_ext;
      plane_mag = plane_num[NMW-1] ? $unsigned(-plane_num + (w_ext <<< 1) - NMW'(1))
                                   : $unsigned(plane_num);
      u_sel     = (cmd.div_sel == DIV_NORM_X) ? u_ff : v_ff;
      u_mag     = u_sel[PW-1] ? $unsigned(-u_sel) : $unsigned(u_sel);
      if (cmd.div_sel == DIV_PLANE_X || cmd.div_sel == DIV_PLANE_Y) begin
         div_num = DW'(plane_mag);
         div_d   = VW'({w_eff, 1'b0});
         div_sgn = plane_num[NMW-1];
      end else begin
         // round half away from zero: add half the divisor to the magnitude
         div_num = (DW'(u_mag) << F) + DW'(len_ff >> 1);
         div_d   = VW'(len_ff);
         div_sgn = u_sel[PW-1];
      end
   end

   always_comb begin
      div_shift  = {div_rem_ff, div_quo_ff[DW-1]};
      div_fit    = div_shift >= {1'b0, div_den_ff};
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_neg_in = div_neg_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_quo_in = div_num;
         div_den_in = div_d;
         div_rem_in = '0;
         div_neg_in = div_sgn;
         div_cnt_in = CW'(DW);
      end else if (div_cnt_ff != '0) begin
         div_quo_in = {div_quo_ff[DW-2:0], div_fit};
         div_rem_in = div_fit ? VW'(div_shift - {1'b0, div_den_ff}) : div_shift[VW-1:0];
         div_cnt_in = div_cnt_ff - CW'(1);
      end
      div_mag = (div_quo_ff > DW'(LIM)) ? LIM : div_quo_ff[PW-1:0];
      div_res = div_neg_ff ? -$signed(div_mag) : $signed(div_mag);
   end

   always_comb begin
      sq_sh     = {sq_rem_ff[RRW-3:0], sq_src_ff[QW-1 -: 2]};
      sq_trial  = RRW'({root_ff, 2'b01});
      sq_fit    = sq_sh >= sq_trial;
      sq_src_in = sq_src_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      sq_cnt_in = sq_cnt_ff;
      if (cmd.sqrt_start) begin
         sq_src_in = need_norm ? QW'(acc_ff) : QW'(ONE2 - acc_ff);
         sq_rem_in = '0;
         root_in   = '0;
         sq_cnt_in = SCW'(RTW);
      end else if (sq_cnt_ff != '0) begin
         sq_src_in = sq_src_ff << 2;
         sq_rem_in = sq_fit ? sq_sh - sq_trial : sq_sh;
         root_in   = {root_ff[RTW-2:0], sq_fit};
         sq_cnt_in = sq_cnt_ff - SCW'(1);
      end
   end

   always_comb begin
      case (cmd.mstep)
         STEP_UU:      begin mul_a = u_ff;      mul_b = u_ff;      end
         STEP_VV:      begin mul_a = v_ff;      mul_b = v_ff;      end
         STEP_DOT_XX:  begin mul_a = PW'(nx_ff); mul_b = PW'(sx_ff); end
         STEP_DOT_YY:  begin mul_a = PW'(ny_ff); mul_b = PW'(sy_ff); end
         STEP_DOT_END: begin mul_a = PW'(nz_ff); mul_b = PW'(sz_ff); end
         STEP_CX_A:    begin mul_a = PW'(ny_ff); mul_b = PW'(sz_ff); end
         STEP_CX_END:  begin mul_a = PW'(nz_ff); mul_b = PW'(sy_ff); end
         STEP_CY_A:    begin mul_a = PW'(nz_ff); mul_b = PW'(sx_ff); end
         STEP_CY_END:  begin mul_a = PW'(nx_ff); mul_b = PW'(sz_ff); end
         STEP_CZ_A:    begin mul_a = PW'(nx_ff); mul_b = PW'(sy_ff); end
         STEP_LAST:    begin mul_a = PW'(ny_ff); mul_b = PW'(sx_ff); end
         default:      begin mul_a = '0;        mul_b = '0;        end
      endcase
      prod_in  = cmd.mul_go ? AW'(mul_a) * AW'(mul_b) : prod_ff;
      acc_base = step_first(cmd.mstep) ? '0 : acc_ff;
      acc_in   = acc_ff;
      if (cmd.acc_go) acc_in = step_sub(cmd.mstep) ? acc_base - prod_ff : acc_base + prod_ff;
      rnd = acc_ff + HALF;
      shr = rnd >>> F;
      if (shr > QMAX)      nar = QMAX[QUAT_W-1:0];
      else if (shr < QMIN) nar = QMIN[QUAT_W-1:0];
      else                 nar = shr[QUAT_W-1:0];
   end

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = csr_data;
            CSR_FRAME_HEIGHT: fh_in = csr_data;
            default: ;
         endcase
      end
      func_in = cmd.capture ? func_type'(req_func) : func_ff;
      px_in   = cmd.capture ? req_pos_x : px_ff;
      py_in   = cmd.capture ? req_pos_y : py_ff;
      u_in = u_ff;  v_in = v_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      len_in = len_ff;
      if (cmd.div_store) begin
         case (cmd.div_sel)
            DIV_PLANE_X: u_in  = div_res;
            DIV_PLANE_Y: v_in  = div_res;
            DIV_NORM_X:  nx_in = SW'(div_res);
            default:     ny_in = SW'(div_res);
         endcase
      end
      if (cmd.sqrt_store) begin
         if (need_norm) begin
            len_in = root_ff;
            nz_in  = '0;
         end else begin
            nx_in = SW'(u_ff);
            ny_in = SW'(v_ff);
            nz_in = SW'(root_ff);
         end
      end
      sx_in = cmd.commit_start ? nx_ff : sx_ff;
      sy_in = cmd.commit_start ? ny_ff : sy_ff;
      sz_in = cmd.commit_start ? nz_ff : sz_ff;
      qw_in = qw_ff; qx_in = qx_ff; qy_in = qy_ff; qz_in = qz_ff;
      if (cmd.narrow_go) begin
         case (cmd.mstep)
            STEP_DOT_END: qw_in = nar;
            STEP_CX_END:  qx_in = nar;
            STEP_CY_END:  qy_in = nar;
            default:      qz_in = nar;
         endcase
      end
      kind_in = kind_ff;
      ow_in = ow_ff; ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      if (cmd.out_load) begin
         kind_in = cmd.out_kind;
         if (cmd.out_kind == REPORT_QUAT) begin
            ow_in = qw_ff; ox_in = qx_ff; oy_in = qy_ff; oz_in = qz_ff;
         end else begin
            ow_in = '0; ox_in = '0; oy_in = '0; oz_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= FRAME_RESET;
         fh_ff      <= FRAME_RESET;
         sx_ff      <= '0;
         sy_ff      <= '0;
         sz_ff      <= '0;
         div_cnt_ff <= '0;
         sq_cnt_ff  <= '0;
      end else begin
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         sz_ff      <= sz_in;
         div_cnt_ff <= div_cnt_in;
         sq_cnt_ff  <= sq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      nz_ff      <= nz_in;
      len_ff     <= len_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_neg_ff <= div_neg_in;
      sq_src_ff  <= sq_src_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      qw_ff      <= qw_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      qz_ff      <= qz_in;
      kind_ff    <= kind_in;
      ow_ff      <= ow_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      oz_ff      <= oz_in;
   end

   assign status.div_done  = (div_cnt_ff == '0);
   assign status.sqrt_done = (sq_cnt_ff == '0);
   assign status.need_norm = need_norm;
   assign status.func      = func_ff;

   assign rsp_report_kind = kind_ff;
   assign rsp_quat_w      = ow_ff;
   assign rsp_quat_x      = ox_ff;
   assign rsp_quat_y      = oy_ff;
   assign rsp_quat_z      = oz_ff;

endmodule

FILE: rtl/arcball_drag_quaternion_unit.sv
`timescale 1ns / 1ps

// Arcball drag unit: turns pointer events into drag reports and rotation
// quaternions (Q2.14 at the default fraction width).
// Input channel req_: one beat per pointer event (func, pos_x, pos_y),
//    taken when req_valid is high and req_stall is low.
// Result channel rsp_: one beat per report, held in an output register
//    while rsp_stall is high; a new event is taken while it waits.
// Configuration csr_: frame width (index 0) and height (index 1); always
//    ready, write only while no event is in flight.
// Work per event:
//    other press, or move/release while not dragging: no result.
//    release while dragging: drag end report to the output register.
//    left press: two divisions, two squares and a square root; two more
//    divisions normalise a point that lies outside the unit disc.
//    move while dragging: as left press plus nine products and 4
//    narrowing steps for the rotation quaternion.
// One radix-2 divider, one digit-serial square root and one multiplier are
// shared by all steps; the divider sets most of the latency.
// Reset: not dragging, start vector zero, both frame sizes 200, no result.
module arcball_drag_quaternion_unit #(
   parameter int FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic signed [adq_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [adq_pkg::POS_W-1:0]  req_pos_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_report_kind,
   output logic signed [adq_pkg::QUAT_W-1:0] rsp_quat_w,
   output logic signed [adq_pkg::QUAT_W-1:0] rsp_quat_x,
   output logic signed [adq_pkg::QUAT_W-1:0] rsp_quat_y,
   output logic signed [adq_pkg::QUAT_W-1:0] rsp_quat_z,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [adq_pkg::CFG_W-1:0]         csr_data
);
   import adq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers accept a beat in any cycle
   assign csr_ready = 1'b1;

   adq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   adq_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_report_kind (rsp_report_kind),
      .rsp_quat_w      (rsp_quat_w),
      .rsp_quat_x      (rsp_quat_x),
      .rsp_quat_y      (rsp_quat_y),
      .rsp_quat_z      (rsp_quat_z)
   );

endmodule
